// ----- src/leg_inverse_kinematics_top_macros.svh -----
// Assertion macros shared by the leg inverse kinematics RTL
`ifndef LEG_INVERSE_KINEMATICS_TOP_MACROS_SVH
`define LEG_INVERSE_KINEMATICS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define LIK_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define LIK_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lik_pkg.sv -----
// Shared constants, types and helper functions for leg inverse kinematics
package lik_pkg;

  localparam int LEGS         = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam int CFG_W  = 49;   // widest configuration register
  localparam int LINK_W = 15;
  localparam int MUL_W  = 34;   // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int VEC_W  = 50;   // CORDIC vector width
  localparam int ANG_W  = 25;   // angle in 1/65536 degree
  localparam int TAB_W  = 22;

  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * 65536);
  localparam logic signed [VEC_W-1:0] LIM_HI  = VEC_W'(64'sd1 << 30);
  localparam logic signed [VEC_W-1:0] LIM_LO  = VEC_W'(64'sd1 << 29);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LINK_HIP   = 3'd0,
    REG_LINK_THIGH = 3'd1,
    REG_LINK_SHIN  = 3'd2,
    REG_MOUNT0     = 3'd3,
    REG_MOUNT1     = 3'd4,
    REG_MOUNT2     = 3'd5,
    REG_MOUNT3     = 3'd6
  } reg_idx_t;

  // atan(2^-i) in 1/65536 degree, rounded
  function automatic logic [TAB_W-1:0] atan_tab(input logic [4:0] i);
    logic [TAB_W-1:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // Round 1/65536 degree to 1/64 degree, keep 16 bits
  function automatic logic [15:0] to_64th(input logic signed [ANG_W:0] a);
    logic signed [ANG_W+1:0] s;
    s = (ANG_W+2)'(a) + (ANG_W+2)'(512);
    return s[25:10];
  endfunction

  function automatic logic too_big(input logic signed [VEC_W-1:0] v);
    return (v >= LIM_HI) || (v <= -LIM_HI);
  endfunction

  function automatic logic too_small(input logic signed [VEC_W-1:0] v);
    return (v < LIM_LO) && (v > -LIM_LO);
  endfunction

endpackage

// ----- src/lik_in_if.sv -----
// Foot target channel
interface lik_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         leg;
  logic signed [15:0] foot_x;
  logic signed [15:0] foot_y;
  logic signed [15:0] foot_z;

  modport source (output valid, leg, foot_x, foot_y, foot_z, input ready);
  modport sink   (input valid, leg, foot_x, foot_y, foot_z, output ready);
endinterface

// ----- src/lik_out_if.sv -----
// Joint angle result channel
interface lik_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         leg_out;
  logic               reachable;
  logic signed [15:0] hip_angle;
  logic signed [15:0] thigh_angle;
  logic signed [15:0] knee_angle;

  modport source (output valid, leg_out, reachable, hip_angle, thigh_angle, knee_angle,
                  input ready);
  modport sink   (input valid, leg_out, reachable, hip_angle, thigh_angle, knee_angle,
                  output ready);
endinterface

// ----- src/leg_inverse_kinematics_top.sv -----
// Three-joint leg inverse kinematics: sequencer, shared multiplier, sqrt and CORDIC
//
// Usage: foot targets (leg, x, y, z in Q11.4 mm) arrive on the target channel and
// joint angles (1/64 degree) leave on the angles channel, both valid/ready.
// Link lengths and per-leg mount offsets are written through cfg_we / cfg_index /
// cfg_data while the block is idle, a rule for the user that the block has no check
// for; an index beyond the register list is dropped. One item is in work at a time;
// target.ready is high only while the sequencer idles. A solved target runs the shared
// square root twice and the shared CORDIC unit four times (16 steps each, after a
// one-bit-per-cycle normalize), besides the shared multiplier; an unreachable target
// stops after the first root and the reach check.
// An unreachable target returns reachable = 0 with the leg's last solved angles.
// A finished result sits in the output register; the next item is accepted while it
// waits, and the sequencer holds its final state if the receiver still stalls.
// Reset (rst, synchronous) restores default link lengths, clears mounts and the
// stored angles of every leg, and empties the output register.
`include "leg_inverse_kinematics_top_macros.svh"

module leg_inverse_kinematics_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [lik_pkg::CFG_W-1:0]   cfg_data,
  lik_in_if.sink                      target,
  lik_out_if.source                   angles
);
  import lik_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_XX, S_YY, S_Q, S_RQ, S_RA, S_ZZ, S_BB, S_CC, S_BC, S_N, S_CHK,
    S_S0, S_S1, S_CS, S_BM, S_CN, S_DEN, S_CGO, S_CWAIT, S_FIN
  } state_t;

  // configuration
  logic [LINK_W-1:0] link_hip, link_thigh, link_shin;
  logic [CFG_W-1:0]  mount [4];

  // per-leg stored angles: hip[15:0], thigh[31:16], knee[47:32]
  logic [47:0]       last_angles [LEGS];

  state_t                   state;
  logic [1:0]               leg;
  logic                     mirror;
  logic                     reach;
  logic                     bad_leg;
  logic signed [16:0]       x, y, z;
  logic signed [18:0]       ra;
  logic signed [39:0]       acc;       // x^2, then N
  logic signed [31:0]       m;
  logic [30:0]              s;
  logic signed [47:0]       cs, den;
  logic [1:0]               job;
  logic signed [ANG_W-1:0]  k_acc, t1_acc, t2_acc, h_acc;

  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [PROD_W-1:0] p;
  logic                     sq_start, sq_done;
  logic [63:0]              sq_val;
  logic [31:0]              sq_root;
  logic                     cor_start, cor_done;
  logic signed [VEC_W-1:0]  cor_y, cor_x;
  logic signed [ANG_W-1:0]  cor_angle;

  logic [CFG_W-1:0]         mt;
  logic signed [16:0]       dx, dy;
  logic signed [39:0]       sum_xy, m_ext, d_lo, d_hi;
  logic [17:0]              r_val;
  logic signed [LINK_W+3:0] b_op, c_op;
  logic                     out_free;

  assign target.ready = (state == S_IDLE);
  assign out_free     = !angles.valid || angles.ready;

  // localize the target at accept
  always_comb begin
    mt = mount[target.leg];
    dx = $signed({target.foot_x[15], target.foot_x}) - $signed({mt[15], mt[15:0]});
    dy = $signed({target.foot_y[15], target.foot_y}) - $signed({mt[31], mt[31:16]});
  end

  // datapath helpers
  always_comb begin
    sum_xy = acc + 40'(p);
    m_ext  = 40'(m);
    d_lo   = m_ext - acc;
    d_hi   = m_ext + acc;
    r_val  = 18'((33'(sq_root) + 33'd1) >> 1);
    b_op   = $signed({4'b0, link_thigh});
    c_op   = $signed({4'b0, link_shin});
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_XX:    begin ma = MUL_W'(x);    mb = MUL_W'(x);    end
      S_YY:    begin ma = MUL_W'(y);    mb = MUL_W'(y);    end
      S_RA:    begin ma = MUL_W'(ra);   mb = MUL_W'(ra);   end
      S_ZZ:    begin ma = MUL_W'(z);    mb = MUL_W'(z);    end
      S_BB:    begin ma = MUL_W'(b_op); mb = MUL_W'(b_op); end
      S_CC:    begin ma = MUL_W'(c_op); mb = MUL_W'(c_op); end
      S_BC:    begin ma = MUL_W'(b_op); mb = MUL_W'(c_op); end
      S_CHK:   begin ma = MUL_W'(d_lo); mb = MUL_W'(d_hi); end
      S_CS:    begin ma = MUL_W'(c_op); mb = $signed({3'b0, s}); end
      S_BM:    begin ma = MUL_W'(b_op); mb = MUL_W'(m);    end
      S_CN:    begin ma = MUL_W'(c_op); mb = MUL_W'(acc);  end
      default: begin ma = '0;           mb = '0;           end
    endcase
  end

  // square root start and operand
  always_comb begin
    sq_start = (state == S_Q) || (state == S_S0);
    sq_val   = (state == S_Q) ? {22'b0, sum_xy, 2'b00} : p[63:0];
  end

  // CORDIC job operands
  always_comb begin
    cor_start = (state == S_CGO);
    unique case (job)
      2'd0:    begin cor_y = $signed({19'b0, s}); cor_x = VEC_W'(acc); end
      2'd1:    begin cor_y = -VEC_W'(z);          cor_x = VEC_W'(ra);  end
      2'd2:    begin cor_y = VEC_W'(cs);          cor_x = VEC_W'(den); end
      default: begin cor_y = VEC_W'(x);           cor_x = VEC_W'(y);   end
    endcase
  end

  lik_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (p)
  );

  lik_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  lik_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .angle (cor_angle)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      link_hip   <= LINK_W'(800);
      link_thigh <= LINK_W'(1600);
      link_shin  <= LINK_W'(1600);
      for (int i = 0; i < 4; i++) begin
        mount[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINK_HIP:   link_hip   <= cfg_data[LINK_W-1:0];
        REG_LINK_THIGH: link_thigh <= cfg_data[LINK_W-1:0];
        REG_LINK_SHIN:  link_shin  <= cfg_data[LINK_W-1:0];
        REG_MOUNT0:     mount[0]   <= cfg_data;
        REG_MOUNT1:     mount[1]   <= cfg_data;
        REG_MOUNT2:     mount[2]   <= cfg_data;
        REG_MOUNT3:     mount[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, stored angles and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      angles.valid <= 1'b0;
      job          <= '0;
      for (int i = 0; i < LEGS; i++) begin
        last_angles[i] <= '0;
      end
    end else begin
      // S_FIN reloads the output register itself when it is taken
      if (angles.valid && angles.ready && state != S_FIN) begin
        angles.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (target.valid) begin
            leg     <= target.leg;
            mirror  <= mt[48];
            x       <= dx;
            y       <= mt[48] ? -dy : dy;
            z       <= $signed({target.foot_z[15], target.foot_z})
                       - $signed({mt[47], mt[47:32]});
            bad_leg <= (int'(target.leg) >= LEGS);
            reach   <= 1'b0;
            job     <= '0;
            state   <= (int'(target.leg) >= LEGS) ? S_FIN : S_XX;
          end
        end
        S_XX: state <= S_YY;
        S_YY: begin
          acc   <= 40'(p);
          state <= S_Q;
        end
        S_Q:  state <= S_RQ;
        S_RQ: begin
          if (sq_done) begin
            ra    <= $signed({1'b0, r_val}) - $signed({4'b0, link_hip});
            state <= S_RA;
          end
        end
        S_RA: state <= S_ZZ;
        S_ZZ: begin
          acc   <= 40'(p);
          state <= S_BB;
        end
        S_BB: begin
          acc   <= acc + 40'(p);
          state <= S_CC;
        end
        S_CC: begin
          acc   <= acc - 40'(p);
          state <= S_BC;
        end
        S_BC: begin
          acc   <= acc - 40'(p);
          state <= S_N;
        end
        S_N: begin
          m     <= 32'(p) <<< 1;
          state <= S_CHK;
        end
        S_CHK: begin
          // |N| > M means the foot is out of reach
          if (acc > m_ext || acc < -m_ext) begin
            state <= S_FIN;
          end else begin
            reach <= 1'b1;
            state <= S_S0;
          end
        end
        S_S0: state <= S_S1;
        S_S1: begin
          if (sq_done) begin
            s     <= sq_root[30:0];
            state <= S_CS;
          end
        end
        S_CS: state <= S_BM;
        S_BM: begin
          cs    <= 48'(p);
          state <= S_CN;
        end
        S_CN: begin
          den   <= 48'(p);
          state <= S_DEN;
        end
        S_DEN: begin
          den   <= den + 48'(p);
          state <= S_CGO;
        end
        S_CGO: state <= S_CWAIT;
        S_CWAIT: begin
          if (cor_done) begin
            unique case (job)
              2'd0:    k_acc  <= cor_angle;
              2'd1:    t1_acc <= cor_angle;
              2'd2:    t2_acc <= cor_angle;
              default: h_acc  <= cor_angle;
            endcase
            job   <= job + 2'd1;
            state <= (job == 2'd3) ? S_FIN : S_CGO;
          end
        end
        S_FIN: begin
          if (out_free) begin
            angles.valid     <= 1'b1;
            angles.leg_out   <= leg;
            angles.reachable <= reach;
            if (bad_leg) begin
              angles.hip_angle   <= '0;
              angles.thigh_angle <= '0;
              angles.knee_angle  <= '0;
            end else if (!reach) begin
              angles.hip_angle   <= last_angles[leg][15:0];
              angles.thigh_angle <= last_angles[leg][31:16];
              angles.knee_angle  <= last_angles[leg][47:32];
            end else begin
              angles.hip_angle   <= to_64th(mirror ? -(ANG_W+1)'(h_acc)
                                                   : (ANG_W+1)'(h_acc));
              angles.thigh_angle <= to_64th((ANG_W+1)'(t1_acc) - (ANG_W+1)'(t2_acc));
              angles.knee_angle  <= to_64th((ANG_W+1)'(k_acc));
              last_angles[leg]   <= {to_64th((ANG_W+1)'(k_acc)),
                                     to_64th((ANG_W+1)'(t1_acc) - (ANG_W+1)'(t2_acc)),
                                     to_64th(mirror ? -(ANG_W+1)'(h_acc)
                                                    : (ANG_W+1)'(h_acc))};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `LIK_ASSERT_NXT(a_accept_leaves_idle, target.valid && target.ready, state != S_IDLE, "accepted item did not start the sequencer")
  `LIK_ASSERT_IMP(a_sqrt_done_expected, sq_done, state == S_RQ || state == S_S1, "square root finished outside a wait state")
  `LIK_ASSERT_IMP(a_cordic_done_expected, cor_done, state == S_CWAIT, "CORDIC finished outside its wait state")
  `LIK_ASSERT_NXT(a_result_loaded, state == S_FIN && out_free, angles.valid && state == S_IDLE, "result not loaded on a free output")

endmodule

// ----- src/lik_mul.sv -----
// Shared signed multiplier with registered product
module lik_mul (
  input  logic                             clk,
  input  logic signed [lik_pkg::MUL_W-1:0]  a,
  input  logic signed [lik_pkg::MUL_W-1:0]  b,
  output logic signed [lik_pkg::PROD_W-1:0] p
);
  import lik_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end
endmodule

// ----- src/lik_isqrt.sv -----
// Iterative floor square root, two radicand bits per cycle
module lik_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] opnd;
  logic [32:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;

  // one restoring digit step
  always_comb begin
    rem_sh = {rem, opnd[63:62]};
    trial  = {1'b0, root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        opnd <= val;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? 33'(rem_sh - trial) : 33'(rem_sh);
        root <= {root[30:0], ge};
        opnd <= opnd << 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- src/lik_cordic.sv -----
// Vectoring CORDIC atan2 with quadrant fold and power-of-two normalize
module lik_cordic (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [lik_pkg::VEC_W-1:0] y_in,
  input  logic signed [lik_pkg::VEC_W-1:0] x_in,
  output logic                            done,
  output logic signed [lik_pkg::ANG_W-1:0] angle
);
  import lik_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_DOWN, C_UP, C_STEP} cstate_t;

  cstate_t                  st;
  logic signed [VEC_W-1:0]  xv, yv;
  logic [STEP_W-1:0]        idx;
  logic signed [VEC_W-1:0]  dx, dy;
  logic [ANG_W-1:0]         tab;

  always_comb begin
    dx  = yv >>> idx;
    dy  = xv >>> idx;
    tab = ANG_W'(atan_tab(5'(idx)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        C_IDLE: begin
          if (start) begin
            if (x_in == '0 && y_in == '0) begin
              angle <= '0;
              done  <= 1'b1;
            end else begin
              // fold left half plane by +-90 degrees
              if (x_in < 0) begin
                if (y_in >= 0) begin
                  xv    <= y_in;
                  yv    <= -x_in;
                  angle <= ANG_90;
                end else begin
                  xv    <= -y_in;
                  yv    <= x_in;
                  angle <= -ANG_90;
                end
              end else begin
                xv    <= x_in;
                yv    <= y_in;
                angle <= '0;
              end
              st <= C_DOWN;
            end
          end
        end
        C_DOWN: begin
          // halve toward zero until both below 2^30
          if (too_big(xv) || too_big(yv)) begin
            xv <= (xv + VEC_W'(xv[VEC_W-1])) >>> 1;
            yv <= (yv + VEC_W'(yv[VEC_W-1])) >>> 1;
          end else begin
            st <= C_UP;
          end
        end
        C_UP: begin
          if (too_small(xv) && too_small(yv)) begin
            xv <= xv <<< 1;
            yv <= yv <<< 1;
          end else begin
            idx <= '0;
            st  <= C_STEP;
          end
        end
        C_STEP: begin
          if (yv > 0) begin
            xv    <= xv + dx;
            yv    <= yv - dy;
            angle <= angle + tab;
          end else begin
            xv    <= xv - dx;
            yv    <= yv + dy;
            angle <= angle - tab;
          end
          if (idx == STEP_W'(CORDIC_STEPS - 1)) begin
            done <= 1'b1;
            st   <= C_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: st <= C_IDLE;
      endcase
    end
  end
endmodule

// ----- tb/sv/leg_inverse_kinematics_top_test.sv -----
// Self-checking testbench for leg_inverse_kinematics_top with a built-in angle predictor
module leg_inverse_kinematics_top_test;
  import lik_pkg::*;

  typedef struct {
    logic [1:0]         leg;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } target_t;

  typedef struct {
    logic [1:0]  leg;
    logic        reach;
    logic [15:0] hip;
    logic [15:0] thigh;
    logic [15:0] knee;
  } joint_t;

  localparam longint ATAN_DEG[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                      58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                      229, 115};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  lik_in_if  tgt();
  lik_out_if ang();

  leg_inverse_kinematics_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .target(tgt), .angles(ang)
  );

  // Shadow of the block's registers and per-leg stored angles
  longint      len_hip, len_thigh, len_shin;
  logic [48:0] mount_reg[4];
  joint_t      stored[4];

  target_t pending_targets[$];
  joint_t  expected_angles[$];
  int      mismatches = 0;
  int      send_gap = 0;
  int      recv_gap = 0;
  bit      steady = 1'b0;

  always #2 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Vectoring CORDIC atan2(yv, xv), 1/65536 degree
  function automatic longint vec_angle(longint yv, longint xv);
    longint acc, t, dx, dy;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; acc = 90 * 65536;
      end else begin
        xv = -yv; yv = t; acc = -90 * 65536;
      end
    end
    while (abs64(xv) >= (64'sd1 << 30) || abs64(yv) >= (64'sd1 << 30)) begin
      xv = xv / 2; yv = yv / 2;
    end
    while (abs64(xv) < (64'sd1 << 29) && abs64(yv) < (64'sd1 << 29)) begin
      xv = xv * 2; yv = yv * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv += dx; yv -= dy; acc += ATAN_DEG[i];
      end else begin
        xv -= dx; yv += dy; acc -= ATAN_DEG[i];
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] deg64(longint acc);
    longint s;
    s = (acc + 512) >>> 10;
    return s[15:0];
  endfunction

  // Solve one foot target, updating the stored angles when reachable
  function automatic joint_t solve_leg(target_t t);
    joint_t o;
    logic [48:0] mt;
    bit mir;
    longint x, y, z, r, ra, n, m, s, h, th, k;
    longint unsigned q;
    mt  = mount_reg[t.leg];
    mir = mt[48];
    x = longint'(t.x) - longint'($signed(mt[15:0]));
    y = longint'(t.y) - longint'($signed(mt[31:16]));
    z = longint'(t.z) - longint'($signed(mt[47:32]));
    if (mir) y = -y;
    q  = longint'(x * x + y * y) * 4;
    r  = longint'((int_sqrt(q) + 1) >> 1);
    ra = r - len_hip;
    n  = ra * ra + z * z - len_thigh * len_thigh - len_shin * len_shin;
    m  = 2 * len_thigh * len_shin;
    if (n > m || n < -m) begin
      o = stored[t.leg];
      o.leg = t.leg;
      o.reach = 1'b0;
      return o;
    end
    s  = longint'(int_sqrt(longint'(m - n) * longint'(m + n)));
    k  = vec_angle(s, n);
    th = vec_angle(-z, ra) - vec_angle(len_shin * s, len_thigh * m + len_shin * n);
    h  = vec_angle(x, y);
    if (mir) h = -h;
    o.leg = t.leg;
    o.reach = 1'b1;
    o.hip = deg64(h);
    o.thigh = deg64(th);
    o.knee = deg64(k);
    stored[t.leg] = o;
    return o;
  endfunction

  // Target driver
  always @(posedge clk) begin
    bit took;
    target_t t;
    if (rst) begin
      tgt.valid <= 1'b0;
    end else begin
      took = tgt.valid && tgt.ready;
      if (took) begin
        t = '{tgt.leg, tgt.foot_x, tgt.foot_y, tgt.foot_z};
        expected_angles.push_back(solve_leg(t));
      end
      if (tgt.valid && !took) begin
        // hold the item
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        tgt.valid <= 1'b0;
      end else if (pending_targets.size() > 0) begin
        t = pending_targets.pop_front();
        tgt.valid <= 1'b1;
        tgt.leg <= t.leg;
        tgt.foot_x <= t.x;
        tgt.foot_y <= t.y;
        tgt.foot_z <= t.z;
        send_gap <= gap_len();
      end else begin
        tgt.valid <= 1'b0;
      end
    end
  end

  // Result monitor and ready driver
  always @(posedge clk) begin
    joint_t e;
    if (rst) begin
      ang.ready <= 1'b0;
    end else begin
      if (ang.valid && ang.ready) begin
        if (expected_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result for leg %0d", ang.leg_out);
        end else begin
          e = expected_angles.pop_front();
          if (ang.leg_out !== e.leg || ang.reachable !== e.reach ||
              ang.hip_angle !== e.hip || ang.thigh_angle !== e.thigh ||
              ang.knee_angle !== e.knee) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp leg %0d r %0b h %0d t %0d k %0d, got %0d %0b %0d %0d %0d",
                       e.leg, e.reach, $signed(e.hip), $signed(e.thigh), $signed(e.knee),
                       ang.leg_out, ang.reachable, ang.hip_angle, ang.thigh_angle,
                       ang.knee_angle);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        ang.ready <= 1'b0;
      end else begin
        ang.ready <= 1'b1;
        recv_gap <= gap_len();
      end
    end
  end

  // Register write, held for one edge; caller lowers cfg_we with reg_done
  task automatic reg_write(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LINK_HIP:   len_hip = val[14:0];
      REG_LINK_THIGH: len_thigh = val[14:0];
      REG_LINK_SHIN:  len_shin = val[14:0];
      default:        mount_reg[idx - REG_MOUNT0] = val[48:0];
    endcase
  endtask

  task automatic reg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_target(int leg, int x, int y, int z);
    target_t t;
    t.leg = leg[1:0];
    t.x = x[15:0];
    t.y = y[15:0];
    t.z = z[15:0];
    pending_targets.push_back(t);
  endtask

  // Wait until every item is sent and answered, then let the block settle
  task automatic drain();
    while (pending_targets.size() > 0 || tgt.valid || expected_angles.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [48:0] rand_mount();
    return {1'($urandom_range(1)), 16'($urandom_range(4000)) - 16'd2000,
            16'($urandom_range(4000)) - 16'd2000, 16'($urandom_range(4000)) - 16'd2000};
  endfunction

  // Directed corners plus random targets; most near the leg's reach
  task automatic load_phase(int n_rand);
    int leg, span;
    logic [48:0] mt;
    add_target(0, 32767, 32767, 32767);
    add_target(1, -32768, -32768, -32768);
    add_target(2, 32767, -32768, 0);
    add_target(3, -32768, 32767, -1);
    for (int l = 0; l < 4; l++) begin
      mt = mount_reg[l];
      // foot on the mount point: zero horizontal vector
      add_target(l, $signed(mt[15:0]), $signed(mt[31:16]), $signed(mt[47:32]));
      add_target(l, $signed(mt[15:0]), $signed(mt[31:16]) + 2400, $signed(mt[47:32]) - 2000);
    end
    span = int'(len_hip + len_thigh + len_shin + 16);
    for (int i = 0; i < n_rand; i++) begin
      leg = $urandom_range(3);
      mt = mount_reg[leg];
      if ($urandom_range(9) < 2)
        add_target(leg, $urandom, $urandom, $urandom);
      else
        add_target(leg, $signed(mt[15:0]) + $urandom_range(2 * span) - span,
                   $signed(mt[31:16]) + $urandom_range(2 * span) - span,
                   $signed(mt[47:32]) + $urandom_range(2 * span) - span);
    end
  endtask

  initial begin
    len_hip = 800;
    len_thigh = 1600;
    len_shin = 1600;
    for (int i = 0; i < 4; i++) begin
      mount_reg[i] = '0;
      stored[i] = '{2'd0, 1'b0, 16'd0, 16'd0, 16'd0};
    end
    tgt.valid = 1'b0;
    tgt.leg = '0;
    tgt.foot_x = '0;
    tgt.foot_y = '0;
    tgt.foot_z = '0;
    ang.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults, full idling
    load_phase(250);
    drain();

    // Typical links, random mounts with mirrored sides, no idling
    reg_write(REG_LINK_HIP, 600);
    reg_write(REG_LINK_THIGH, 1800);
    reg_write(REG_LINK_SHIN, 2000);
    for (int l = 0; l < 4; l++) reg_write(reg_idx_t'(REG_MOUNT0 + l), rand_mount());
    // index beyond the list is dropped
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data <= '1;
    reg_done();
    steady = 1'b1;
    load_phase(250);
    drain();
    steady = 1'b0;

    // Extreme links and mounts
    reg_write(REG_LINK_HIP, 32767);
    reg_write(REG_LINK_THIGH, 32767);
    reg_write(REG_LINK_SHIN, 32767);
    reg_write(REG_MOUNT0, 49'h1_8000_8000_8000);
    reg_write(REG_MOUNT1, 49'h0_7FFF_7FFF_7FFF);
    reg_write(REG_MOUNT2, 49'h1_FFFF_FFFF_FFFF);
    reg_write(REG_MOUNT3, 49'h0);
    reg_done();
    load_phase(250);
    drain();

    // Zero hip offset and thigh: only the exact shin distance is reachable
    reg_write(REG_LINK_HIP, 0);
    reg_write(REG_LINK_THIGH, 0);
    reg_write(REG_LINK_SHIN, 1600);
    reg_write(REG_MOUNT0, 49'h0);
    reg_write(REG_MOUNT1, 49'h0);
    reg_write(REG_MOUNT2, 49'h1_0000_0000_0000);
    reg_done();
    add_target(0, 1600, 0, 0);
    add_target(1, 0, 0, -1600);
    add_target(2, 0, 1600, 0);
    add_target(1, 0, 0, -1601);
    load_phase(40);
    drain();

    // Minimum links, random mounts
    reg_write(REG_LINK_HIP, 1);
    reg_write(REG_LINK_THIGH, 1);
    reg_write(REG_LINK_SHIN, 1);
    for (int l = 0; l < 4; l++) reg_write(reg_idx_t'(REG_MOUNT0 + l), rand_mount());
    reg_done();
    load_phase(60);
    // back to moderate links for the rest
    drain();
    reg_write(REG_LINK_HIP, 800);
    reg_write(REG_LINK_THIGH, 1700);
    reg_write(REG_LINK_SHIN, 1500);
    reg_done();
    load_phase(200);
    drain();

    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
